@@ rtl/tns_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tns_pkg
// shared types, operation codes and defaults of the timed note sequencer
// ---------------------------------------------------------------------------
package tns_pkg;

  localparam int DEF_NOTE_DEPTH = 256;
  localparam int DEF_KEY_BITS   = 16;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_EXT   = 3'd2;
  localparam logic [2:0] OP_REWND = 3'd3;
  localparam logic [2:0] OP_SEEK  = 3'd4;
  localparam logic [2:0] OP_RUN   = 3'd5;
  localparam logic [2:0] OP_FIRST = 3'd6;

  localparam logic REG_PITCH  = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  localparam logic [15:0] PITCH_RESET = 16'd256;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] note_key;
    logic [31:0] time_value;
    logic [19:0] frame_delta;
    logic        run_flag;
  } in_item_t;

  typedef struct packed {
    logic        fired;
    logic [15:0] fired_key;
    logic        finished;
    logic [31:0] current_time;
    logic [7:0]  note_index;
    logic        status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic exec;
    logic scan;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_seek;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/tns_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tns_ctrl
// sequencing state machine: accept, calc, execute or scan, write result
// ---------------------------------------------------------------------------
module tns_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tns_pkg::sts_t sts,
  output tns_pkg::cmd_t cmd
);
  import tns_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = sts.is_seek ? S_SCAN : S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_WRITE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/tns_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tns_datapath
// note tables, play state, tick arithmetic, seek scan and output register
// ---------------------------------------------------------------------------
module tns_datapath #(
  parameter int NOTE_DEPTH = tns_pkg::DEF_NOTE_DEPTH,
  parameter int KEY_BITS   = tns_pkg::DEF_KEY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  tns_pkg::in_item_t   in_data,
  output tns_pkg::out_item_t  out_data,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  tns_pkg::cmd_t       cmd,
  output tns_pkg::sts_t       sts
);
  import tns_pkg::*;

  localparam int IDX_W = $clog2(NOTE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(NOTE_DEPTH);

  logic [KEY_BITS-1:0] note_keys  [NOTE_DEPTH];
  logic [31:0]         note_times [NOTE_DEPTH];

  in_item_t            item;
  logic [35:0]         prod;
  logic [15:0]         pitch;
  logic [31:0]         time_offset;
  logic [CNT_W-1:0]    note_count;
  logic [IDX_W-1:0]    play_index;
  logic [31:0]         play_time;
  logic                running;
  logic                done_flag;
  logic                fired;
  logic [KEY_BITS-1:0] fired_key;
  logic                status;
  logic [IDX_W-1:0]    rd_addr;
  logic [31:0]         rd_time;
  logic [KEY_BITS-1:0] rd_key;
  logic [CNT_W-1:0]    scan_cnt;
  logic                scan_vld;
  logic [IDX_W-1:0]    scan_idx;

  logic [32:0]         tick_sum;
  logic [33:0]         lead_time;
  logic                tick_due;
  logic                ext_due;
  logic                can_fire;
  logic [CNT_W-1:0]    index_inc;
  logic [47:0]         key_ext;
  logic [IDX_W+7:0]    index_ext;
  logic [KEY_BITS+15:0] fkey_ext;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch       <= PITCH_RESET;
      time_offset <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PITCH:  pitch       <= cfg_data[15:0];
        REG_OFFSET: time_offset <= cfg_data;
        default:    ;
      endcase
    end
  end

  // item latch and tick product
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
      prod <= {16'd0, in_data.frame_delta} * {20'd0, pitch};
    end
  end

  // table read, one address a cycle
  always_comb begin
    if (cmd.scan) begin
      rd_addr = scan_cnt[IDX_W-1:0];
    end else if (item.operation == OP_FIRST) begin
      rd_addr = '0;
    end else begin
      rd_addr = play_index;
    end
  end

  always_ff @(posedge clk) begin
    rd_time <= note_times[rd_addr];
    rd_key  <= note_keys[rd_addr];
  end

  assign key_ext = {32'd0, item.note_key};

  always_ff @(posedge clk) begin
    if (cmd.exec && item.operation == OP_PUSH && note_count < DEPTH_C) begin
      note_times[note_count[IDX_W-1:0]] <= item.time_value;
      note_keys[note_count[IDX_W-1:0]]  <= key_ext[KEY_BITS-1:0];
    end
  end

  assign tick_sum  = {1'b0, play_time} + {5'd0, prod[35:8]};
  assign lead_time = {2'b00, play_time} + {{2{time_offset[31]}}, time_offset};
  assign tick_due  = $signed(lead_time) > $signed({2'b00, rd_time});
  assign ext_due   = play_time > rd_time;
  assign can_fire  = !done_flag && (note_count != '0);
  assign index_inc = {1'b0, play_index} + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      note_count <= '0;
      play_index <= '0;
      play_time  <= '0;
      running    <= 1'b0;
      done_flag  <= 1'b0;
      scan_cnt   <= '0;
      scan_vld   <= 1'b0;
    end else begin
      if (cmd.calc) begin
        fired     <= 1'b0;
        fired_key <= '0;
        status    <= 1'b0;
        scan_cnt  <= '0;
        scan_vld  <= 1'b0;
        if (item.operation == OP_TICK && running) begin
          play_time <= tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
        end else if (item.operation == OP_EXT) begin
          play_time <= item.time_value;
        end
      end
      if (cmd.exec) begin
        case (item.operation)
          OP_PUSH: begin
            if (note_count < DEPTH_C) begin
              note_count <= note_count + CNT_W'(1);
            end else begin
              status <= 1'b1;
            end
          end
          OP_TICK, OP_EXT: begin
            if (can_fire && ((item.operation == OP_TICK && running && tick_due) ||
                             (item.operation == OP_EXT && ext_due))) begin
              fired     <= 1'b1;
              fired_key <= rd_key;
              if (index_inc == note_count) begin
                done_flag <= 1'b1;
              end else begin
                play_index <= index_inc[IDX_W-1:0];
              end
            end
          end
          OP_REWND: begin
            play_index <= '0;
            play_time  <= '0;
          end
          OP_RUN: begin
            running <= item.run_flag;
            if (item.run_flag) begin
              done_flag <= 1'b0;
            end
          end
          OP_FIRST: begin
            play_index <= '0;
            if (note_count != '0) begin
              play_time <= rd_time;
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan) begin
        // read stage then compare stage, last match wins
        if (scan_cnt < note_count) begin
          scan_cnt <= scan_cnt + CNT_W'(1);
          scan_vld <= 1'b1;
          scan_idx <= scan_cnt[IDX_W-1:0];
        end else begin
          scan_vld <= 1'b0;
        end
        if (scan_vld && item.time_value > rd_time) begin
          play_time  <= rd_time;
          play_index <= scan_idx;
        end
      end
    end
  end

  assign sts.is_seek   = (item.operation == OP_SEEK);
  assign sts.scan_done = (scan_cnt == note_count) && !scan_vld;
  assign sts.out_free  = !out_valid || out_ready;

  // output register
  assign index_ext = {8'd0, play_index};
  assign fkey_ext  = {16'd0, fired_key};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.fired        <= fired;
      out_data.fired_key    <= fkey_ext[15:0];
      out_data.finished     <= done_flag;
      out_data.current_time <= play_time;
      out_data.note_index   <= index_ext[7:0];
      out_data.status       <= status;
    end
  end

endmodule

@@ rtl/timed_note_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timed_note_sequencer_unit
// plays back a loaded table of key and time notes under tick, external time,
// seek, rewind and run control
// ---------------------------------------------------------------------------
// result: each input transfer but seek goes through the calc, execute and write states
// seek: calc, then scan with one table entry read per cycle on the read port, then write
// the write state waits for a free output; next item taken once the result is registered
// reset: synchronous, clears play state, note count, flags; pitch back to 1.0
// note tables are not cleared; only entries below the note count are used
module timed_note_sequencer_unit #(
  parameter int NOTE_DEPTH = tns_pkg::DEF_NOTE_DEPTH,
  parameter int KEY_BITS   = tns_pkg::DEF_KEY_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // input item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  tns_pkg::in_item_t  in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output tns_pkg::out_item_t out_data,
  // config write port: index 0 pitch, index 1 time offset
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import tns_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller steps each transfer through calc, execute or scan, write
  tns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds tables, play state, config and the output register
  tns_datapath #(
    .NOTE_DEPTH (NOTE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
